[hw/rtl/speculative_taint_window_monitor_unit_macros.svh]
// Assertion shorthands shared by the monitor RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef SPECULATIVE_TAINT_WINDOW_MONITOR_UNIT_MACROS_SVH
`define SPECULATIVE_TAINT_WINDOW_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication
`define STWM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define STWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stwm_pkg.sv]
`timescale 1ns / 1ps

package stwm_pkg;

    localparam int PC_W      = 64;
    localparam int REG_W     = 8;
    localparam int TOTAL_W   = 32;
    localparam int UCOUNT_W  = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [UCOUNT_W-1:0] UCOUNT_MAX = '1;
    localparam logic [PC_W-1:0]     PC_NONE    = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_SQUASHED = 2'd1,
        ST_TAINTED  = 2'd2
    } monitor_state_t;

    typedef struct packed {
        logic [PC_W-1:0]  pc;
        logic             committed;
        logic             issued;
        logic             completed;
        logic             is_load;
        logic             micro_visible;
        logic             is_nop;
        logic             has_dest;
        logic [REG_W-1:0] dest_reg;
        logic [1:0]       src_count;
        logic [REG_W-1:0] src1_reg;
        logic [REG_W-1:0] src2_reg;
    } item_t;

    typedef struct packed {
        logic                vulnerable_found;
        logic [PC_W-1:0]     window_pc;
        logic                new_unique_window;
        logic [TOTAL_W-1:0]  flushed_count;
        logic [UCOUNT_W-1:0] unique_flushed_count;
        logic [TOTAL_W-1:0]  vulnerable_count;
        logic [UCOUNT_W-1:0] unique_vulnerable_count;
        logic                store_overflow;
        logic [1:0]          monitor_state;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [PC_W-1:0]      wdata;
    } cfg_write_t;

    // Store lookup outcome for one transfer
    typedef struct packed {
        logic fresh;     // add requested and pc not present
        logic overflow;  // fresh but the chain was full
    } store_rsp_t;

    // Clamp a store occupancy to the 7-bit report field
    function automatic logic [UCOUNT_W-1:0] clamp_count(input logic [TOTAL_W-1:0] v);
        logic [UCOUNT_W-1:0] r;
        if (v > TOTAL_W'(UCOUNT_MAX)) begin
            r = UCOUNT_MAX;
        end
        else begin
            r = v[UCOUNT_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/stwm_stream_if.sv]
`timescale 1ns / 1ps

interface stwm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/speculative_taint_window_monitor_unit.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Payload      | Notes
// item     | in  | item_t       | one retired or squashed instruction per transfer
// result   | out | result_t     | one result per item, held in an output register
// cfg      | in  | cfg_write_t  | window_start (0) / window_end (1), always ready
//
// One item per cycle sustained while result.ready is high; its result appears in the
// output register in the cycle after the transfer. The step is combinational: the PC
// store search is a parallel compare across the cell row (PC_STORE_DEPTH cells per store).
// A new item is taken while the result waits, if result.ready is high that cycle.
// Reset clears state at once (taint bits and store valid flags are flops): no
// clearing pass.

`include "speculative_taint_window_monitor_unit_macros.svh"

module speculative_taint_window_monitor_unit
    import stwm_pkg::*;
#(
    parameter int PHYS_REGS      = 256,
    parameter int PC_STORE_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    stwm_stream_if.sink   item,
    stwm_stream_if.source result,
    stwm_stream_if.sink   cfg
);

    localparam int CW = $clog2(PC_STORE_DEPTH + 1);

    // Configuration
    logic [PC_W-1:0] window_start_reg;
    logic [PC_W-1:0] window_end_reg;
    logic [PC_W-1:0] window_end_m1_reg;

    // Monitor state
    monitor_state_t     state_reg;
    monitor_state_t     state_next;
    logic [PC_W-1:0]    opening_pc_reg;
    logic [PC_W-1:0]    opening_pc_next;
    logic               inside_reg;
    logic               inside_next;
    logic [TOTAL_W-1:0] flush_total_reg;
    logic [TOTAL_W-1:0] flush_total_next;
    logic [TOTAL_W-1:0] vuln_total_reg;
    logic [TOTAL_W-1:0] vuln_total_next;

    // Output register
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;

    logic accept;
    logic monitored;
    logic load_done;
    logic t1;
    logic t2;
    logic src1_taint;
    logic src2_taint;
    logic clear_taint;
    logic mark_dest;
    logic flush_add;
    logic found;
    logic flush_inc;

    store_rsp_t    flush_rsp;
    store_rsp_t    vuln_rsp;
    logic [CW-1:0] flush_cnt_next;
    logic [CW-1:0] vuln_cnt_next;

    item_t in_d;

    assign in_d       = item.data;
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            window_start_reg  <= PC_NONE;
            window_end_reg    <= '0;
            window_end_m1_reg <= PC_NONE;
        end
        else if (cfg.valid) begin
            unique case (cfg.data.reg_index)
                CFG_WINDOW_START: window_start_reg <= cfg.data.wdata;
                CFG_WINDOW_END:
                begin
                    window_end_reg    <= cfg.data.wdata;
                    window_end_m1_reg <= cfg.data.wdata - PC_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Address window tracking
    always_comb
    begin
        inside_next = inside_reg || (in_d.pc == window_start_reg);
        if (inside_next && ((in_d.pc == window_end_reg) || (in_d.pc == window_end_m1_reg))) begin
            inside_next = 1'b0;
        end
    end

    assign monitored = inside_next && !in_d.is_nop;
    assign load_done = in_d.is_load && in_d.completed && in_d.has_dest;
    assign t1        = (in_d.src_count != 2'd0) && src1_taint;
    assign t2        = in_d.src_count[1] && src2_taint;

    // Automaton next state
    always_comb
    begin
        state_next      = state_reg;
        opening_pc_next = opening_pc_reg;
        clear_taint     = 1'b0;
        mark_dest       = 1'b0;
        flush_add       = 1'b0;
        flush_inc       = 1'b0;
        found           = 1'b0;
        if (monitored) begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    clear_taint     = 1'b1;
                    opening_pc_next = PC_NONE;
                    if (!in_d.committed) begin
                        opening_pc_next = in_d.pc;
                        flush_inc       = 1'b1;
                        flush_add       = 1'b1;
                        if (load_done) begin
                            mark_dest  = 1'b1;
                            state_next = ST_TAINTED;
                        end
                        else begin
                            state_next = ST_SQUASHED;
                        end
                    end
                end
                ST_SQUASHED:
                begin
                    if (in_d.committed) begin
                        state_next = ST_IDLE;
                    end
                    else if (load_done) begin
                        mark_dest  = 1'b1;
                        state_next = ST_TAINTED;
                    end
                end
                ST_TAINTED:
                begin
                    if (in_d.committed) begin
                        state_next = ST_IDLE;
                    end
                    else if (in_d.issued && in_d.micro_visible && (t1 || t2)) begin
                        found      = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (in_d.issued && (in_d.is_load || t1 || t2)) begin
                        mark_dest = in_d.has_dest;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // Saturating totals
    assign flush_total_next = (flush_inc && (flush_total_reg != '1)) ?
                              flush_total_reg + TOTAL_W'(1) : flush_total_reg;
    assign vuln_total_next  = (found && (vuln_total_reg != '1)) ?
                              vuln_total_reg + TOTAL_W'(1) : vuln_total_reg;

    // Per-register taint bitmap
    stwm_taint_map #(
        .PHYS_REGS (PHYS_REGS)
    ) u_taint (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept && clear_taint),
        .set_en     (accept && mark_dest),
        .dest_reg   (in_d.dest_reg),
        .src1_reg   (in_d.src1_reg),
        .src2_reg   (in_d.src2_reg),
        .src1_taint (src1_taint),
        .src2_taint (src2_taint)
    );

    // Distinct window-opening PCs
    stwm_pc_store #(
        .DEPTH (PC_STORE_DEPTH),
        .CW    (CW)
    ) u_flush_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .add_req    (accept && flush_add),
        .query      (in_d.pc),
        .rsp        (flush_rsp),
        .count_next (flush_cnt_next)
    );

    // Distinct vulnerable window PCs
    stwm_pc_store #(
        .DEPTH (PC_STORE_DEPTH),
        .CW    (CW)
    ) u_vuln_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .add_req    (accept && found),
        .query      (opening_pc_reg),
        .rsp        (vuln_rsp),
        .count_next (vuln_cnt_next)
    );

    // Result assembly
    always_comb
    begin
        out_next.vulnerable_found        = found;
        out_next.window_pc               = opening_pc_next;
        out_next.new_unique_window       = vuln_rsp.fresh;
        out_next.flushed_count           = flush_total_next;
        out_next.unique_flushed_count    = clamp_count(TOTAL_W'(flush_cnt_next));
        out_next.vulnerable_count        = vuln_total_next;
        out_next.unique_vulnerable_count = clamp_count(TOTAL_W'(vuln_cnt_next));
        out_next.store_overflow          = flush_rsp.overflow || vuln_rsp.overflow;
        out_next.monitor_state           = state_next;
    end

    // Monitor state update on each item transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            opening_pc_reg  <= PC_NONE;
            inside_reg      <= 1'b0;
            flush_total_reg <= '0;
            vuln_total_reg  <= '0;
        end
        else if (accept) begin
            state_reg       <= state_next;
            opening_pc_reg  <= opening_pc_next;
            inside_reg      <= inside_next;
            flush_total_reg <= flush_total_next;
            vuln_total_reg  <= vuln_total_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (accept) begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Checks
    `STWM_ASSERT_IMPLIES(a_ready_when_empty, !out_valid_reg, item.ready, "input stalled with empty output")
    `STWM_ASSERT_IMPLIES(a_found_goes_idle, out_valid_reg && out_reg.vulnerable_found, out_reg.monitor_state == ST_IDLE, "vulnerable result without return to idle")
    `STWM_ASSERT_NEXT(a_found_counted, accept && found, vuln_total_reg != '0, "vulnerable window not counted")
    `STWM_ASSERT_IMPLIES(a_unique_le_total, out_valid_reg, TOTAL_W'(out_reg.unique_flushed_count) <= out_reg.flushed_count, "more distinct window PCs than windows")

endmodule

[hw/rtl/stwm_pc_cell.sv]
`timescale 1ns / 1ps

module stwm_pc_cell
    import stwm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  logic [PC_W-1:0] prev_pc,
    input  logic            prev_valid,
    input  logic [PC_W-1:0] query,
    output logic [PC_W-1:0] pc,
    output logic            valid,
    output logic            match
);

    logic [PC_W-1:0] pc_reg;
    logic            valid_reg;

    // Occupancy flag follows its neighbor on a shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (shift_en) begin
            valid_reg <= prev_valid;
        end
    end

    // Stored PC, no reset needed
    always_ff @(posedge clk)
    begin
        if (shift_en) begin
            pc_reg <= prev_pc;
        end
    end

    assign pc    = pc_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (pc_reg == query);

endmodule

[hw/rtl/stwm_pc_store.sv]
`timescale 1ns / 1ps

module stwm_pc_store
    import stwm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            add_req,
    input  logic [PC_W-1:0] query,
    output store_rsp_t      rsp,
    output logic [CW-1:0]   count_next
);

    logic [PC_W-1:0] cell_pc [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_match;
    logic [CW-1:0]    count_reg;
    logic             hit;
    logic             full;
    logic             insert;

    // Row of cells: a new PC enters at cell 0 and every entry moves one over
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [PC_W-1:0] prev_pc;
        logic            prev_valid;

        if (i == 0) begin : g_head
            assign prev_pc    = query;
            assign prev_valid = 1'b1;
        end
        else begin : g_body
            assign prev_pc    = cell_pc[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        stwm_pc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (insert),
            .prev_pc    (prev_pc),
            .prev_valid (prev_valid),
            .query      (query),
            .pc         (cell_pc[i]),
            .valid      (cell_valid[i]),
            .match      (cell_match[i])
        );
    end

    // Parallel search and insert decision
    assign hit    = |cell_match;
    assign full   = cell_valid[DEPTH-1];
    assign insert = add_req && !hit && !full;

    assign rsp.fresh    = add_req && !hit;
    assign rsp.overflow = add_req && !hit && full;

    assign count_next = count_reg + CW'(insert);

    // Occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/stwm_taint_map.sv]
`timescale 1ns / 1ps

module stwm_taint_map
    import stwm_pkg::*;
#(
    parameter int PHYS_REGS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             set_en,
    input  logic [REG_W-1:0] dest_reg,
    input  logic [REG_W-1:0] src1_reg,
    input  logic [REG_W-1:0] src2_reg,
    output logic             src1_taint,
    output logic             src2_taint
);

    localparam int RW = (PHYS_REGS > 1) ? $clog2(PHYS_REGS) : 1;

    logic [PHYS_REGS-1:0] bits_reg;
    logic [PHYS_REGS-1:0] bits_next;
    logic [RW-1:0]        dst_idx;
    logic [RW-1:0]        s1_idx;
    logic [RW-1:0]        s2_idx;
    logic                 dst_ok;
    logic                 s1_ok;
    logic                 s2_ok;

    // Register indexes beyond the file are never tainted
    assign dst_ok = 32'(dest_reg) < 32'(PHYS_REGS);
    assign s1_ok  = 32'(src1_reg) < 32'(PHYS_REGS);
    assign s2_ok  = 32'(src2_reg) < 32'(PHYS_REGS);
    assign dst_idx = RW'(dest_reg);
    assign s1_idx  = RW'(src1_reg);
    assign s2_idx  = RW'(src2_reg);

    assign src1_taint = s1_ok && bits_reg[s1_idx];
    assign src2_taint = s2_ok && bits_reg[s2_idx];

    // Clear happens before the set within one transfer
    always_comb
    begin
        for (int i = 0; i < PHYS_REGS; i++) begin
            bits_next[i] = (bits_reg[i] && !clear) || (set_en && dst_ok && (dst_idx == RW'(i)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bits_reg <= '0;
        end
        else begin
            bits_reg <= bits_next;
        end
    end

endmodule

[verif/tb_speculative_taint_window_monitor_unit.sv]
`timescale 1ns / 1ps

module tb_speculative_taint_window_monitor_unit;
    import stwm_pkg::*;

    localparam int PC_STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT    = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // TB-owned drive registers, known from time zero
    logic       instr_valid  = 1'b0;
    item_t      instr_data   = '0;
    logic       report_ready = 1'b0;
    logic       cfg_valid    = 1'b0;
    cfg_write_t cfg_data     = '0;

    stwm_stream_if #(.payload_t(item_t))      item_ch ();
    stwm_stream_if #(.payload_t(result_t))    result_ch ();
    stwm_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

    assign item_ch.valid   = instr_valid;
    assign item_ch.data    = instr_data;
    assign result_ch.ready = report_ready;
    assign cfg_ch.valid    = cfg_valid;
    assign cfg_ch.data     = cfg_data;

    speculative_taint_window_monitor_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor model state (mirrors the block)
    logic [PC_W-1:0]    watch_start     = PC_NONE;
    logic [PC_W-1:0]    watch_end       = '0;
    monitor_state_t     fsm             = ST_IDLE;
    logic [PC_W-1:0]    opening_pc      = PC_NONE;
    logic               in_window       = 1'b0;
    logic [255:0]       taint_map       = '0;
    logic [PC_W-1:0]    opener_seen[$];
    logic [PC_W-1:0]    vulnerable_pcs[$];
    logic [TOTAL_W-1:0] flushed_total    = '0;
    logic [TOTAL_W-1:0] vulnerable_total = '0;

    item_t      pending_instrs[$];
    cfg_write_t pending_cfg_writes[$];
    result_t    expected_reports[$];

    int send_hold    = 0;
    int send_calm    = 0;
    int sink_hold    = 0;
    int sink_calm    = 0;
    int mismatches   = 0;
    int reports_seen = 0;
    int cycle_count  = 0;
    int queued_instrs = 0;

    logic [PC_W-1:0] gen_start = PC_NONE;
    logic [PC_W-1:0] gen_end   = '0;
    logic [PC_W-1:0] opener_pool[96];

    result_t want_rep;
    result_t got_rep;

    function automatic logic [TOTAL_W-1:0] bump_total(logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic pc_known(logic [PC_W-1:0] pcs[$], logic [PC_W-1:0] pc);
        foreach (pcs[i])
        begin
            if (pcs[i] == pc)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one instruction to the model and return the report it produces
    function automatic result_t predict_report(item_t it);
        result_t rep;
        logic    hit1;
        logic    hit2;
        logic    load_done;
        logic    found;
        logic    fresh;
        logic    overflow;
        found    = 1'b0;
        fresh    = 1'b0;
        overflow = 1'b0;

        if (it.pc == watch_start)
            in_window = 1'b1;
        if (in_window && (it.pc == watch_end || it.pc == watch_end - 64'd1))
            in_window = 1'b0;

        if (in_window && !it.is_nop)
        begin
            hit1      = (it.src_count >= 2'd1) && taint_map[it.src1_reg];
            hit2      = (it.src_count >= 2'd2) && taint_map[it.src2_reg];
            load_done = it.is_load && it.completed && it.has_dest;
            case (fsm)
                ST_IDLE:
                begin
                    taint_map  = '0;
                    opening_pc = PC_NONE;
                    if (!it.committed)
                    begin
                        opening_pc    = it.pc;
                        flushed_total = bump_total(flushed_total);
                        if (!pc_known(opener_seen, it.pc))
                        begin
                            if (opener_seen.size() < PC_STORE_DEPTH)
                                opener_seen = {opener_seen, it.pc};
                            else
                                overflow = 1'b1;
                        end
                        if (load_done)
                        begin
                            taint_map[it.dest_reg] = 1'b1;
                            fsm = ST_TAINTED;
                        end
                        else
                            fsm = ST_SQUASHED;
                    end
                end
                ST_SQUASHED:
                begin
                    if (it.committed)
                        fsm = ST_IDLE;
                    else if (load_done)
                    begin
                        taint_map[it.dest_reg] = 1'b1;
                        fsm = ST_TAINTED;
                    end
                end
                default:
                begin
                    if (it.committed)
                        fsm = ST_IDLE;
                    else if (it.issued && it.micro_visible && (hit1 || hit2))
                        found = 1'b1;
                    else if (it.issued && (it.is_load || hit1 || hit2))
                    begin
                        if (it.has_dest)
                            taint_map[it.dest_reg] = 1'b1;
                    end
                end
            endcase

            // Vulnerable window: record opener, back to idle
            if (found)
            begin
                vulnerable_total = bump_total(vulnerable_total);
                fresh = !pc_known(vulnerable_pcs, opening_pc);
                if (fresh)
                begin
                    if (vulnerable_pcs.size() < PC_STORE_DEPTH)
                        vulnerable_pcs = {vulnerable_pcs, opening_pc};
                    else
                        overflow = 1'b1;
                end
                fsm = ST_IDLE;
            end
        end

        rep.vulnerable_found        = found;
        rep.window_pc               = opening_pc;
        rep.new_unique_window       = fresh;
        rep.flushed_count           = flushed_total;
        rep.unique_flushed_count    = UCOUNT_W'(opener_seen.size());
        rep.vulnerable_count        = vulnerable_total;
        rep.unique_vulnerable_count = UCOUNT_W'(vulnerable_pcs.size());
        rep.store_overflow          = overflow;
        rep.monitor_state           = fsm;
        return rep;
    endfunction

    // Pause length: mostly short, a few long, with calm stretches of none
    function automatic int pause_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Instruction and config drivers; model updated on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instr_valid <= 1'b0;
            instr_data  <= '0;
            send_hold   <= 0;
            cfg_valid   <= 1'b0;
            cfg_data    <= '0;
        end
        else
        begin
            if (instr_valid && item_ch.ready)
                expected_reports = {expected_reports, predict_report(instr_data)};
            if (cfg_valid && cfg_ch.ready)
            begin
                if (cfg_data.reg_index == CFG_WINDOW_START)
                    watch_start = cfg_data.wdata;
                else if (cfg_data.reg_index == CFG_WINDOW_END)
                    watch_end = cfg_data.wdata;
            end

            if (!instr_valid || item_ch.ready)
            begin
                if (send_hold > 0)
                begin
                    instr_valid <= 1'b0;
                    send_hold   <= send_hold - 1;
                end
                else if (pending_instrs.size() > 0)
                begin
                    instr_data  <= pending_instrs.pop_front();
                    instr_valid <= 1'b1;
                    send_hold   <= pause_len(send_calm);
                end
                else
                    instr_valid <= 1'b0;
            end

            if (!cfg_valid || cfg_ch.ready)
            begin
                if (pending_cfg_writes.size() > 0)
                begin
                    cfg_data  <= pending_cfg_writes.pop_front();
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // Report sink with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_ready <= 1'b0;
            sink_hold    <= 0;
        end
        else if (sink_hold > 0)
        begin
            report_ready <= 1'b0;
            sink_hold    <= sink_hold - 1;
        end
        else
        begin
            report_ready <= 1'b1;
            sink_hold    <= pause_len(sink_calm);
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("mismatch on report %0d, %s: expected %h, got %h",
                         reports_seen, name, want, got);
            mismatches++;
        end
    endtask

    // Report checker
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && report_ready)
        begin
            got_rep = result_ch.data;
            if (expected_reports.size() == 0)
            begin
                if (mismatches < 10)
                    $display("report %0d arrived with nothing expected: %p",
                             reports_seen, got_rep);
                mismatches++;
            end
            else
            begin
                want_rep = expected_reports.pop_front();
                check_field("vulnerable_found", 64'(want_rep.vulnerable_found),
                            64'(got_rep.vulnerable_found));
                check_field("window_pc", want_rep.window_pc, got_rep.window_pc);
                check_field("new_unique_window", 64'(want_rep.new_unique_window),
                            64'(got_rep.new_unique_window));
                check_field("flushed_count", 64'(want_rep.flushed_count),
                            64'(got_rep.flushed_count));
                check_field("unique_flushed_count", 64'(want_rep.unique_flushed_count),
                            64'(got_rep.unique_flushed_count));
                check_field("vulnerable_count", 64'(want_rep.vulnerable_count),
                            64'(got_rep.vulnerable_count));
                check_field("unique_vulnerable_count",
                            64'(want_rep.unique_vulnerable_count),
                            64'(got_rep.unique_vulnerable_count));
                check_field("store_overflow", 64'(want_rep.store_overflow),
                            64'(got_rep.store_overflow));
                check_field("monitor_state", 64'(want_rep.monitor_state),
                            64'(got_rep.monitor_state));
            end
            reports_seen++;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic item_t mk(logic [63:0] pc, bit committed, bit issued, bit completed,
                                 bit is_load, bit mv, bit nop, bit has_dest,
                                 logic [7:0] dest, logic [1:0] nsrc,
                                 logic [7:0] s1, logic [7:0] s2);
        item_t it;
        it.pc            = pc;
        it.committed     = committed;
        it.issued        = issued;
        it.completed     = completed;
        it.is_load       = is_load;
        it.micro_visible = mv;
        it.is_nop        = nop;
        it.has_dest      = has_dest;
        it.dest_reg      = dest;
        it.src_count     = nsrc;
        it.src1_reg      = s1;
        it.src2_reg      = s2;
        return it;
    endfunction

    function automatic logic [PC_W-1:0] any_pc();
        return {$urandom, $urandom};
    endfunction

    // Fully random instruction at a given PC, no-op one time in eight
    function automatic item_t any_instr(logic [PC_W-1:0] pc);
        item_t it;
        it        = item_t'({$urandom, $urandom, $urandom, $urandom});
        it.pc     = pc;
        it.is_nop = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    task automatic queue_instr(item_t it);
        pending_instrs = {pending_instrs, it};
        queued_instrs++;
    endtask

    task automatic write_window(logic [PC_W-1:0] s, logic [PC_W-1:0] e);
        cfg_write_t w;
        w.reg_index = CFG_WINDOW_START;
        w.wdata     = s;
        pending_cfg_writes = {pending_cfg_writes, w};
        w.reg_index = CFG_WINDOW_END;
        w.wdata     = e;
        pending_cfg_writes = {pending_cfg_writes, w};
        while (pending_cfg_writes.size() != 0 || cfg_valid)
            @(posedge clk);
        gen_start = s;
        gen_end   = e;
    endtask

    // Hold the sender until every report is back, then let the block settle
    task automatic drain();
        while (reports_seen < queued_instrs)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Commit, squash that taints a register, optional propagation, then a reader
    task automatic queue_window_attempt();
        item_t           it;
        logic [7:0]      d;
        logic [7:0]      d2;
        logic [7:0]      target;
        logic [PC_W-1:0] opener;
        int              fillers;
        d  = 8'($urandom);
        d2 = d;

        it = any_instr(any_pc());
        it.committed = 1'b1;
        it.is_nop    = 1'b0;
        queue_instr(it);

        opener = ($urandom_range(0, 9) < 7) ? opener_pool[$urandom_range(0, 95)] : any_pc();
        it = any_instr(opener);
        it.committed = 1'b0;
        it.is_nop    = 1'b0;
        if ($urandom_range(0, 1) == 1)
        begin
            it.is_load   = 1'b1;
            it.completed = 1'b1;
            it.has_dest  = 1'b1;
            it.dest_reg  = d;
            queue_instr(it);
        end
        else
        begin
            it.is_load = 1'b0;
            queue_instr(it);
            it = any_instr(any_pc());
            it.committed = 1'b0;
            it.is_nop    = 1'b0;
            it.is_load   = 1'b1;
            it.completed = 1'b1;
            it.has_dest  = 1'b1;
            it.dest_reg  = d;
            queue_instr(it);
        end

        fillers = $urandom_range(0, 2);
        for (int k = 0; k < fillers; k++)
        begin
            it = any_instr(any_pc());
            it.committed     = 1'b0;
            it.micro_visible = 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                it.issued    = 1'b1;
                it.has_dest  = 1'b1;
                it.src_count = 2'd1;
                it.src1_reg  = d;
                if (!it.is_nop)
                    d2 = it.dest_reg;
            end
            queue_instr(it);
        end

        target = ($urandom_range(0, 1) == 1) ? d : d2;
        it = any_instr(any_pc());
        it.committed     = 1'b0;
        it.is_nop        = 1'b0;
        it.issued        = ($urandom_range(0, 6) != 0);
        it.micro_visible = 1'b1;
        it.src_count     = 2'($urandom_range(1, 3));
        if (it.src_count == 2'd1 || $urandom_range(0, 1) == 1)
            it.src1_reg = target;
        else
            it.src2_reg = target;
        queue_instr(it);
    endtask

    task automatic queue_random_phase(int count);
        int    goal;
        int    r;
        item_t it;
        goal = queued_instrs + count;
        queue_instr(any_instr(gen_start));
        while (queued_instrs < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_window_attempt();
            else if (r < 85)
                queue_instr(any_instr(any_pc()));
            else if (r < 93)
            begin
                // leave the window, stray outside, usually come back
                it = any_instr(($urandom_range(0, 1) == 1) ? gen_end : gen_end - 64'd1);
                queue_instr(it);
                queue_instr(any_instr(any_pc()));
                if ($urandom_range(0, 4) != 0)
                    queue_instr(any_instr(gen_start));
            end
            else
                queue_instr(any_instr(gen_start));
        end
    endtask

    // Stimulus sequence
    initial
    begin
        logic [PC_W-1:0] same;
        foreach (opener_pool[i])
            opener_pool[i] = any_pc();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset window settings watch nothing: start matches end - 1
        queue_instr(mk('1, 0, 1, 1, 1, 1, 0, 1, 8'h01, 2'd0, 8'h00, 8'h00));
        queue_instr(mk('0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 2'd0, 8'h00, 8'h00));
        queue_instr(mk('1, 0, 1, 0, 0, 1, 0, 0, 8'h00, 2'd1, 8'h01, 8'h00));
        drain();

        // Widest window: every automaton path by hand
        write_window('0, '1);
        queue_instr(mk(64'h0, 1, 0, 0, 0, 0, 0, 0, 8'h00, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hA000, 0, 1, 1, 1, 1, 0, 1, 8'hFF, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hB000, 0, 1, 0, 0, 1, 1, 0, 8'h00, 2'd2, 8'hFF, 8'hFF));
        queue_instr(mk(64'hC000, 0, 1, 1, 0, 1, 0, 0, 8'h00, 2'd3, 8'h00, 8'hFF));
        queue_instr(mk(64'hA000, 0, 0, 1, 1, 0, 0, 0, 8'h10, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hD000, 0, 1, 1, 1, 0, 0, 0, 8'h10, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hD008, 0, 1, 1, 1, 0, 0, 1, 8'h00, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hE000, 0, 1, 0, 0, 0, 0, 1, 8'h20, 2'd1, 8'h00, 8'h00));
        queue_instr(mk(64'hF000, 0, 1, 0, 1, 0, 0, 1, 8'h30, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hF100, 0, 1, 0, 1, 0, 0, 0, 8'h40, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hF200, 0, 1, 0, 0, 1, 0, 0, 8'h00, 2'd1, 8'h01, 8'h20));
        queue_instr(mk(64'hF300, 0, 1, 0, 0, 1, 0, 0, 8'h00, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hF400, 0, 0, 0, 0, 1, 0, 0, 8'h00, 2'd2, 8'h01, 8'h30));
        queue_instr(mk(64'hF500, 0, 1, 0, 0, 1, 0, 0, 8'h00, 2'd2, 8'h01, 8'h20));
        queue_instr(mk(64'hF600, 1, 0, 0, 0, 0, 0, 0, 8'h00, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hF700, 0, 0, 0, 0, 0, 0, 0, 8'h00, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hF800, 1, 0, 0, 0, 0, 0, 0, 8'h00, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hF900, 0, 1, 1, 1, 1, 0, 1, 8'h05, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'hFA00, 1, 1, 1, 0, 1, 0, 0, 8'h00, 2'd1, 8'h05, 8'h00));
        queue_instr(mk(64'hFFFF_FFFF_FFFF_FFFE, 0, 1, 1, 1, 1, 0, 1, 8'h06, 2'd0,
                       8'h00, 8'h00));
        queue_instr(mk(64'hFB00, 0, 1, 1, 1, 1, 0, 1, 8'h07, 2'd0, 8'h00, 8'h00));
        queue_instr(mk('1, 0, 1, 1, 1, 1, 0, 1, 8'h08, 2'd0, 8'h00, 8'h00));
        queue_instr(mk(64'h0, 0, 1, 1, 1, 1, 0, 1, 8'h09, 2'd0, 8'h00, 8'h00));
        drain();

        // Start equal to end: the window closes on the item that opens it
        same = any_pc();
        write_window(same, same);
        queue_instr(mk(same, 0, 1, 1, 1, 1, 0, 1, 8'h11, 2'd0, 8'h00, 8'h00));
        for (int k = 0; k < 5; k++)
            queue_instr(any_instr(any_pc()));
        drain();

        write_window(any_pc(), any_pc());
        queue_random_phase(250);
        drain();

        // End of zero: its predecessor wraps to all ones
        write_window(any_pc(), '0);
        queue_random_phase(200);
        drain();

        write_window('1, 64'd1);
        queue_random_phase(250);
        drain();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
